// ----- design/sliding_median_mean_filter_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sliding median / mean filter unit
// Implication checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_MEAN_FILTER_UNIT_MACROS_SVH
`define SLIDING_MEDIAN_MEAN_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SMMF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SMMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SMMF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SMMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/smmf_pkg.sv -----
// ---------------------------------------------------------------------------
// smmf_pkg
// Register indexes, field widths and reset values for the filter unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package smmf_pkg;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 5;
	localparam int CHANNEL_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

	localparam logic MODE_MEDIAN = 1'b0;
	localparam logic MODE_MEAN = 1'b1;

	localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 5'd10;
endpackage

// ----- design/smmf_sort_cell.sv -----
// ---------------------------------------------------------------------------
// smmf_sort_cell
// One cell of the insertion sort chain: keeps the smaller, passes the larger.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module smmf_sort_cell import smmf_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          in_vld,
	input  logic signed [SAMPLE_BITS-1:0] in_val,
	output logic                          out_vld,
	output logic signed [SAMPLE_BITS-1:0] out_val,
	output logic signed [SAMPLE_BITS-1:0] held_val
);
	logic held_vld_q;
	logic out_vld_q;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (clear) begin
			held_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= in_vld && held_vld_q;
			if (in_vld) begin
				held_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			if (!held_vld_q) begin
				held_q <= in_val;
			end else if (in_val < held_q) begin
				held_q <= in_val;
				out_q <= held_q;
			end else begin
				out_q <= in_val;
			end
		end
	end

	assign out_vld = out_vld_q;
	assign out_val = out_q;
	assign held_val = held_q;
endmodule

// ----- design/smmf_divider.sv -----
// ---------------------------------------------------------------------------
// smmf_divider
// Restoring divider for unsigned values, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module smmf_divider import smmf_pkg::*; #(
	parameter int MAG_W = 20,
	parameter int DIV_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic [MAG_W-1:0] quotient
);
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0] shifted;
	logic ge;

	assign shifted = {rem_q[DIV_W-1:0], quo_q[MAG_W-1]};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(MAG_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? shifted - {1'b0, dvs_q} : shifted;
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quo_q;
endmodule

// ----- design/sliding_median_mean_filter_unit.sv -----
// ---------------------------------------------------------------------------
// sliding_median_mean_filter_unit
// Per-channel sliding window filter giving the median or the truncated mean.
// ---------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid / in_ready  sample, channel
// out      out_valid/out_ready  filtered, window_full, out_channel
// cfg      cfg_write            cfg_index, cfg_data
//
// An item whose window is not yet full goes straight to the output stage.
// For a full window, N memory reads feed the sort chain, then the chain
// settles while the serial divider runs. Reset clears fill counts; the
// window memory needs no clearing.
// A new item is taken while a finished result waits at the output register.
`timescale 1ns / 1ps
module sliding_median_mean_filter_unit import smmf_pkg::*; #(
	parameter int CHANNELS = 4,
	parameter int WINDOW_MAX = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [CHANNEL_W-1:0]          channel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          window_full,
	output logic [CHANNEL_W-1:0]          out_channel,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);
	`include "sliding_median_mean_filter_unit_macros.svh"

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int ADDR_W = $clog2(CHANNELS * WINDOW_MAX);
	localparam int DEPTH = CHANNELS * WINDOW_MAX;
	localparam int MAG_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int SUM_W = MAG_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_FEED = 3'd2;
	localparam logic [2:0] S_SETTLE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	function automatic logic [CH_W-1:0] fold_channel(input logic [CHANNEL_W-1:0] c);
		int v;
		v = int'(c);
		for (int k = 0; k < 3; k++) begin
			if (v >= CHANNELS) begin
				v = v - CHANNELS;
			end
		end
		return CH_W'(v);
	endfunction

	logic [2:0] state_q;
	logic mode_q;
	logic [CFG_DATA_W-1:0] wlen_q;
	logic [LEN_W-1:0] n_cur;
	logic [LEN_W-1:0] fill_q [CHANNELS];
	logic [SLOT_W-1:0] ptr_q [CHANNELS];

	logic accept;
	logic [CH_W-1:0] ch_in;
	logic [LEN_W-1:0] fc;
	logic [SLOT_W-1:0] wslot;
	logic [LEN_W-1:0] fill_new;
	logic [SLOT_W-1:0] ptr_new;
	logic full_new;

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic issue_s1;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	logic [CH_W-1:0] ch_q;
	logic [CHANNEL_W-1:0] ch_raw_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic full_q;
	logic [LEN_W-1:0] n_q;
	logic item_mode_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic [LEN_W:0] cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic neg_q;

	logic div_start;
	logic div_busy;
	logic [MAG_W-1:0] div_mag;
	logic [MAG_W-1:0] quo;

	logic link_vld [WINDOW_MAX+1];
	logic signed [SAMPLE_BITS-1:0] link_val [WINDOW_MAX+1];
	logic signed [SAMPLE_BITS-1:0] held [WINDOW_MAX];

	logic signed [SAMPLE_BITS-1:0] result;
	logic load_out;

	always_comb begin
		if (wlen_q == '0) begin
			n_cur = LEN_W'(1);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			n_cur = LEN_W'(WINDOW_MAX);
		end else begin
			n_cur = LEN_W'(wlen_q);
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign accept = in_valid && in_ready;
	assign ch_in = fold_channel(channel);
	assign fc = fill_q[ch_in];

	always_comb begin
		if (fc >= n_cur) begin
			wslot = ptr_q[ch_in];
			fill_new = n_cur;
			ptr_new = (LEN_W'(ptr_q[ch_in]) + 1'b1 == n_cur) ? '0 : ptr_q[ch_in] + 1'b1;
		end else begin
			wslot = SLOT_W'(fc);
			fill_new = fc + 1'b1;
			ptr_new = '0;
		end
		full_new = fill_new >= n_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MEDIAN;
			wlen_q <= WINDOW_LENGTH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FILTER_MODE: mode_q <= cfg_data[0];
				CFG_WINDOW_LENGTH: wlen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A new window length restarts every channel's window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
				ptr_q[i] <= '0;
			end
		end else if (cfg_write && cfg_index == CFG_WINDOW_LENGTH) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
				ptr_q[i] <= '0;
			end
		end else if (accept) begin
			fill_q[ch_in] <= fill_new;
			ptr_q[ch_in] <= ptr_new;
		end
	end

	assign waddr = ADDR_W'(ch_in) * ADDR_W'(WINDOW_MAX) + ADDR_W'(wslot);
	assign raddr = ADDR_W'(ch_q) * ADDR_W'(WINDOW_MAX) + ADDR_W'(rd_idx_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[waddr] <= sample;
		end
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_s1 <= 1'b0;
			rd_idx_q <= '0;
			cnt_q <= '0;
		end else begin
			issue_s1 <= state_q == S_READ;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						cnt_q <= '0;
						state_q <= full_new ? S_READ : S_DONE;
					end
				end
				S_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (LEN_W'(rd_idx_q) + 1'b1 == n_q) begin
						state_q <= S_FEED;
					end
				end
				S_FEED: state_q <= S_SETTLE;
				S_SETTLE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q > {1'b0, n_q} && !div_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= ch_in;
			ch_raw_q <= channel;
			sample_q <= sample;
			full_q <= full_new;
			n_q <= n_cur;
			item_mode_q <= mode_q;
			sum_q <= '0;
		end else if (issue_s1) begin
			sum_q <= sum_q + SUM_W'(rd_s1);
		end
		if (div_start) begin
			neg_q <= sum_q[SUM_W-1];
		end
	end

	// The sum is complete on the first settle cycle.
	assign div_start = state_q == S_SETTLE && cnt_q == '0;
	assign div_mag = MAG_W'(sum_q[SUM_W-1] ? -sum_q : sum_q);

	smmf_divider #(
		.MAG_W(MAG_W),
		.DIV_W(LEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_mag),
		.divisor(n_q),
		.busy(div_busy),
		.quotient(quo)
	);

	assign link_vld[0] = issue_s1;
	assign link_val[0] = rd_s1;

	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		smmf_sort_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.clear(accept),
			.in_vld(link_vld[g]),
			.in_val(link_val[g]),
			.out_vld(link_vld[g+1]),
			.out_val(link_val[g+1]),
			.held_val(held[g])
		);
	end

	always_comb begin
		if (!full_q) begin
			result = sample_q;
		end else if (item_mode_q == MODE_MEAN) begin
			result = SAMPLE_BITS'(neg_q ? -quo : quo);
		end else begin
			result = held[SLOT_W'(n_q >> 1)];
		end
	end

	assign load_out = state_q == S_DONE && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered <= result;
			window_full <= full_q;
			out_channel <= ch_raw_q;
		end
	end

	`SMMF_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)
	`SMMF_ASSERT_SAME(a_fill_in_range, clk, arst_n, 1'b1, fill_q[0] <= n_cur)
	`SMMF_ASSERT_NEXT(a_length_write_clears, clk, arst_n,
		cfg_write && cfg_index == CFG_WINDOW_LENGTH, fill_q[0] == '0)
endmodule

// ----- sim/tb_sliding_median_mean_filter_unit.sv -----
// ---------------------------------------------------------------------------
// tb_sliding_median_mean_filter_unit
// Drives samples on random channels through the filter unit across several
// window lengths and both filter modes, predicts every result and compares
// it field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sliding_median_mean_filter_unit import smmf_pkg::*;;

	localparam int NCH = 4;
	localparam int WMAX = 16;
	localparam int SW = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [SW-1:0] filtered;
		logic                 window_full;
		logic [1:0]           out_channel;
	} filter_result_t;

	class filter_scoreboard;
		logic signed [SW-1:0] history [NCH][WMAX];
		int unsigned fill [NCH];
		int unsigned oldest [NCH];
		logic mode;
		int unsigned win_len;
		filter_result_t pending [$];
		int errors;

		function void reset_state();
			for (int c = 0; c < NCH; c++) begin
				fill[c] = 0;
				oldest[c] = 0;
			end
			mode = MODE_MEDIAN;
			win_len = WINDOW_LENGTH_RESET;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_FILTER_MODE) begin
				mode = val[0];
			end else begin
				win_len = val;
				for (int c = 0; c < NCH; c++) begin
					fill[c] = 0;
					oldest[c] = 0;
				end
			end
		endfunction

		function void note_sample(logic signed [SW-1:0] x, logic [1:0] ch);
			int unsigned n;
			int unsigned p;
			int unsigned i;
			int unsigned j;
			longint sum;
			logic signed [SW-1:0] sorted [WMAX];
			logic signed [SW-1:0] v;
			filter_result_t r;
			n = (win_len == 0) ? 1 : (win_len > WMAX ? WMAX : win_len);
			if (fill[ch] >= n) begin
				p = oldest[ch] % n;
				history[ch][p] = x;
				oldest[ch] = (p + 1) % n;
				fill[ch] = n;
			end else begin
				history[ch][fill[ch] % WMAX] = x;
				fill[ch]++;
				oldest[ch] = 0;
			end
			r.filtered = x;
			r.window_full = 1'b0;
			r.out_channel = ch;
			if (fill[ch] >= n) begin
				r.window_full = 1'b1;
				if (mode == MODE_MEDIAN) begin
					for (i = 0; i < n; i++) begin
						v = history[ch][i];
						j = i;
						while (j > 0 && sorted[j-1] > v) begin
							sorted[j] = sorted[j-1];
							j--;
						end
						sorted[j] = v;
					end
					r.filtered = sorted[n/2];
				end else begin
					sum = 0;
					for (i = 0; i < n; i++)
						sum += history[ch][i];
					r.filtered = SW'(sum / longint'(n));
				end
			end
			pending = {pending, r};
		endfunction

		function void check_result(filter_result_t got);
			filter_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.filtered !== exp_r.filtered)
				$display("%0t: filtered expected %0d actual %0d", $time,
					exp_r.filtered, got.filtered);
			if (got.window_full !== exp_r.window_full)
				$display("%0t: window_full expected %0b actual %0b", $time,
					exp_r.window_full, got.window_full);
			if (got.out_channel !== exp_r.out_channel)
				$display("%0t: out_channel expected %0d actual %0d", $time,
					exp_r.out_channel, got.out_channel);
			if (got !== exp_r)
				errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SW-1:0] sample;
	logic [1:0] channel;
	logic out_valid;
	logic out_ready;
	logic signed [SW-1:0] filtered;
	logic window_full;
	logic [1:0] out_channel;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	filter_scoreboard sb;
	int unsigned cycles;
	int unsigned hold_off;

	sliding_median_mean_filter_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .channel(channel),
		.out_valid(out_valid), .out_ready(out_ready), .filtered(filtered),
		.window_full(window_full), .out_channel(out_channel),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		in_valid = 1'b0;
		sample = '0;
		channel = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_off = 0;
		cycles = 0;
		sb = new();
		sb.reset_state();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_sliding_median_mean_filter_unit: done, errors");
			$finish;
		end
	end

	// Receiver: stalls on its own pattern, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{filtered, window_full, out_channel});
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (cycles[9]) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_register(idx, val);
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [SW-1:0] x, logic [1:0] ch);
		in_valid <= 1'b1;
		sample <= x;
		channel <= ch;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(x, ch);
	endtask

	// A burst keeps valid high across items; it drops only in the gap after.
	task automatic send_burst(int unsigned count, bit biased);
		logic signed [SW-1:0] x;
		int unsigned gap;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 5))
				0: x = 16'sh7fff;
				1: x = 16'sh8000;
				default: x = biased ? SW'($urandom_range(0, 2047)) - 16'sd1024 : SW'($urandom);
			endcase
			send_sample(x, 2'($urandom_range(0, 3)));
		end
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		// A short idle stretch separates one phase from the next.
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int unsigned lens [6];
		lens = '{1, 16, 10, 2, 0, 31};
		wait (arst_n === 1'b1);
		@(posedge clk);
		// Directed: field extremes on every channel at the reset window length.
		for (int k = 0; k < 22; k++)
			send_sample((k % 3 == 0) ? 16'sh8000 : (k % 3 == 1) ? 16'sh7fff : SW'(k),
				k[1:0]);
		drain();
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_FILTER_MODE, CFG_DATA_W'(ph[0] ? MODE_MEAN : MODE_MEDIAN));
			write_reg(CFG_WINDOW_LENGTH,
				CFG_DATA_W'((ph < 6) ? lens[ph] : $urandom_range(1, 16)));
			if (ph == 3)
				hold_off = 400;
			for (int b = 0; b < 10; b++)
				send_burst($urandom_range(1, 10), ph[1]);
			drain();
		end
		if (sb.errors == 0)
			$display("tb_sliding_median_mean_filter_unit: done, clean");
		else
			$display("tb_sliding_median_mean_filter_unit: done, errors");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/smmf_pkg.sv
design/smmf_sort_cell.sv
design/smmf_divider.sv
design/sliding_median_mean_filter_unit.sv
sim/tb_sliding_median_mean_filter_unit.sv
